// ===== hw/rtl/two_button_gesture_decoder_defines.svh =====
// assertion macros for the two-button gesture decoder
`ifndef TWO_BUTTON_GESTURE_DECODER_DEFINES_SVH
`define TWO_BUTTON_GESTURE_DECODER_DEFINES_SVH

// same-cycle implication, checked on every clock outside reset
`define TBGD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tbgd assertion failed");

// next-cycle implication
`define TBGD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tbgd assertion failed");

`endif

// ===== hw/rtl/tbgd_pkg.sv =====
// types and constants shared by the gesture decoder modules
`timescale 1ns / 1ps

package tbgd_pkg;

	localparam int TICK_BITS  = 32;
	localparam int CNT_BITS   = 8;
	localparam int HOLD_BITS  = 32;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 8;

	localparam logic [CNT_BITS-1:0] COUNT_MAX = 8'd255;
	localparam logic [CNT_BITS-1:0] DEBOUNCE_RESET = 8'd3;
	localparam logic [HOLD_BITS-1:0] HOLD_RESET = 32'd2000;

	typedef logic [TICK_BITS-1:0] tick_t;

	typedef enum logic [2:0] {
		CMD_NONE         = 3'd0,
		CMD_RESET_PROV   = 3'd1,
		CMD_ENTER_PROMPT = 3'd2,
		CMD_B1_PRESS     = 3'd3,
		CMD_B2_PRESS     = 3'd4,
		CMD_CANCEL       = 3'd5,
		CMD_START        = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_PROMPT = 2'd1,
		MODE_PROV   = 2'd2,
		MODE_OTHER  = 2'd3
	} mode_t;

	typedef enum logic [0:0] {
		CFG_DEBOUNCE = 1'b0,
		CFG_HOLD     = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [CNT_BITS-1:0]  debounce_samples;
		logic [HOLD_BITS-1:0] hold_ticks;
	} cfg_t;

	// debounced level and its edges for one button
	typedef struct packed {
		logic pressed;
		logic rose;
		logic fell;
	} deb_t;

	typedef struct packed {
		cmd_t first_cmd;
		cmd_t second_cmd;
	} cmds_t;

endpackage

// ===== hw/rtl/tbgd_debounce.sv =====
// same-value counter debouncer with edge detect for one button
`timescale 1ns / 1ps

module tbgd_debounce (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          raw,
	input  logic [tbgd_pkg::CNT_BITS-1:0] debounce_samples,
	output tbgd_pkg::deb_t                deb
);
	import tbgd_pkg::*;

	logic                stable_q;
	logic                prev_raw_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [CNT_BITS-1:0] cnt_n;
	logic                stable_n;

	always_comb begin
		if (raw == prev_raw_q) begin
			cnt_n = (cnt_q < COUNT_MAX) ? cnt_q + CNT_BITS'(1) : cnt_q;
		end else begin
			cnt_n = '0;
		end
		stable_n = (cnt_n >= debounce_samples) ? raw : stable_q;
	end

	// previous stable level is the stored one
	assign deb.pressed = stable_n;
	assign deb.rose    = stable_n & ~stable_q;
	assign deb.fell    = ~stable_n & stable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q   <= 1'b0;
			prev_raw_q <= 1'b0;
			cnt_q      <= '0;
		end else if (en) begin
			stable_q   <= stable_n;
			prev_raw_q <= raw;
			cnt_q      <= cnt_n;
		end
	end

endmodule

// ===== hw/rtl/tbgd_gesture.sv =====
// hold, combo and short-release detection with per-mode command selection
`timescale 1ns / 1ps

module tbgd_gesture (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  tbgd_pkg::deb_t                 deb1,
	input  tbgd_pkg::deb_t                 deb2,
	input  tbgd_pkg::tick_t                now,
	input  logic [1:0]                     mode,
	input  logic [tbgd_pkg::HOLD_BITS-1:0] hold_ticks,
	output tbgd_pkg::cmds_t                cmds
);
	import tbgd_pkg::*;

	tick_t down_tick_q;
	logic  hold_sent_q;
	logic  prev_both_q;
	tick_t both_start_q;
	logic  both_fired_q;
	logic  combo_q;

	tick_t down_tick_n;
	logic  hold_sent_n;
	logic  hold_sent_tmp;
	tick_t both_start_n;
	logic  both_fired_n;
	logic  both_fired_tmp;
	logic  combo_n;
	logic  both;
	logic  both_fire;
	logic  b1_hold;
	logic  quiet;
	tick_t held1;
	tick_t both_held;
	cmd_t  cand [4];

	always_comb begin
		both = deb1.pressed & deb2.pressed;

		down_tick_n   = deb1.rose ? now : down_tick_q;
		hold_sent_tmp = (deb1.rose | deb1.fell) ? 1'b0 : hold_sent_q;
		held1         = deb1.pressed ? now - down_tick_n : '0;

		if (both) begin
			combo_n = 1'b1;
		end else if (!deb1.pressed && !deb2.pressed) begin
			combo_n = 1'b0;
		end else begin
			combo_n = combo_q;
		end

		both_start_n   = (both && !prev_both_q) ? now : both_start_q;
		both_fired_tmp = (both && prev_both_q) ? both_fired_q : 1'b0;
		both_held      = now - both_start_n;
		both_fire      = both & ~both_fired_tmp & (HOLD_BITS'(both_held) >= hold_ticks);
		both_fired_n   = both_fired_tmp | both_fire;

		b1_hold = ~both & deb1.pressed & ~hold_sent_tmp & (HOLD_BITS'(held1) >= hold_ticks);
		// short releases only count outside a two-button gesture
		quiet   = ~combo_n & ~both_fired_n;

		cand[0]     = both_fire ? CMD_RESET_PROV : CMD_NONE;
		cand[1]     = CMD_NONE;
		cand[2]     = CMD_NONE;
		cand[3]     = CMD_NONE;
		hold_sent_n = hold_sent_tmp;
		unique case (mode_t'(mode))
			MODE_NORMAL: begin
				cand[1]     = b1_hold ? CMD_ENTER_PROMPT : CMD_NONE;
				cand[2]     = (quiet && deb1.fell) ? CMD_B1_PRESS : CMD_NONE;
				cand[3]     = (quiet && deb2.fell) ? CMD_B2_PRESS : CMD_NONE;
				hold_sent_n = hold_sent_tmp | b1_hold;
			end
			MODE_PROMPT: begin
				cand[1]     = b1_hold ? CMD_CANCEL : CMD_NONE;
				cand[2]     = (quiet && deb2.fell) ? CMD_START : CMD_NONE;
				hold_sent_n = hold_sent_tmp | b1_hold;
			end
			MODE_PROV: begin
				cand[1]     = b1_hold ? CMD_CANCEL : CMD_NONE;
				hold_sent_n = hold_sent_tmp | b1_hold;
			end
			MODE_OTHER: begin
			end
			default: begin
			end
		endcase

		// first two commands in send order
		cmds.first_cmd  = CMD_NONE;
		cmds.second_cmd = CMD_NONE;
		for (int i = 0; i < 4; i++) begin
			if (cand[i] != CMD_NONE) begin
				if (cmds.first_cmd == CMD_NONE) begin
					cmds.first_cmd = cand[i];
				end else if (cmds.second_cmd == CMD_NONE) begin
					cmds.second_cmd = cand[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_tick_q  <= '0;
			hold_sent_q  <= 1'b0;
			prev_both_q  <= 1'b0;
			both_start_q <= '0;
			both_fired_q <= 1'b0;
			combo_q      <= 1'b0;
		end else if (en) begin
			down_tick_q  <= down_tick_n;
			hold_sent_q  <= hold_sent_n;
			prev_both_q  <= both;
			both_start_q <= both_start_n;
			both_fired_q <= both_fired_n;
			combo_q      <= combo_n;
		end
	end

endmodule

// ===== hw/rtl/two_button_gesture_decoder.sv =====
// two-button gesture decoder top level: input stage, decode logic, result register
//
// channel   direction  payload
// s_axis    in         poll sample: raw levels, tick count, ui mode
// m_axis    out        command pair and debounced levels
// cfg       in         register write: debounce samples, hold ticks
//
// one sample per cycle sustained while m_axis_tready stays high
// the sample sits in the input stage, the decode runs in one pass into the result register
// button state advances only when the input stage moves into the result register
// a stalled result keeps the input stage full; s_axis_tready drops once both are held
// reset clears the valid flags and button state and loads debounce 3 and hold 2000
`timescale 1ns / 1ps
`include "two_button_gesture_decoder_defines.svh"

module two_button_gesture_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// raw_button1, raw_button2, now_tick[31:0], ui_mode[1:0], zero pad
	input  logic [tbgd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// first_cmd[2:0], second_cmd[2:0], stable_button1, stable_button2
	output logic [tbgd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_we,
	input  logic                            cfg_addr,
	input  logic [tbgd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import tbgd_pkg::*;

	cfg_t       cfg_q;
	logic       valid_s1;
	logic       raw1_s1;
	logic       raw2_s1;
	tick_t      now_s1;
	logic [1:0] mode_s1;
	logic       valid_s2;
	cmds_t      cmds_s2;
	logic       stable1_s2;
	logic       stable2_s2;
	logic       advance;
	deb_t       deb1;
	deb_t       deb2;
	cmds_t      cmds;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_samples <= DEBOUNCE_RESET;
			cfg_q.hold_ticks       <= HOLD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_addr))
				CFG_DEBOUNCE: cfg_q.debounce_samples <= cfg_wdata[CNT_BITS-1:0];
				CFG_HOLD:     cfg_q.hold_ticks <= cfg_wdata[HOLD_BITS-1:0];
				default:      cfg_q <= cfg_q;
			endcase
		end
	end

	assign advance       = valid_s1 & (~valid_s2 | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			raw1_s1 <= s_axis_tdata[0];
			raw2_s1 <= s_axis_tdata[1];
			now_s1  <= s_axis_tdata[2 +: TICK_BITS];
			mode_s1 <= s_axis_tdata[34 +: 2];
		end
	end

	tbgd_debounce u_deb1 (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (advance),
		.raw              (raw1_s1),
		.debounce_samples (cfg_q.debounce_samples),
		.deb              (deb1)
	);

	tbgd_debounce u_deb2 (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (advance),
		.raw              (raw2_s1),
		.debounce_samples (cfg_q.debounce_samples),
		.deb              (deb2)
	);

	tbgd_gesture u_gesture (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.deb1       (deb1),
		.deb2       (deb2),
		.now        (now_s1),
		.mode       (mode_s1),
		.hold_ticks (cfg_q.hold_ticks),
		.cmds       (cmds)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmds_s2    <= cmds;
			stable1_s2 <= deb1.pressed;
			stable2_s2 <= deb2.pressed;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {stable2_s2, stable1_s2, cmds_s2.second_cmd, cmds_s2.first_cmd};

	// a second command never appears without a first
	`TBGD_ASSERT_NOW(a_cmd_order, m_axis_tvalid && cmds_s2.first_cmd == CMD_NONE, cmds_s2.second_cmd == CMD_NONE)
	// input side backs up whenever both stages are held
	`TBGD_ASSERT_NOW(a_backpressure, valid_s1 && valid_s2 && !m_axis_tready, !s_axis_tready)
	// a sample leaving the input stage always lands as a result beat
	`TBGD_ASSERT_NEXT(a_advance_lands, advance, m_axis_tvalid)
	// both-hold and single-button hold cannot fire in one sample
	`TBGD_ASSERT_NOW(a_hold_excl, m_axis_tvalid && cmds_s2.first_cmd == CMD_RESET_PROV, cmds_s2.second_cmd == CMD_NONE)

endmodule
